>>> rtl/cabnf_pkg.sv
// Package with operation codes, flag positions and shared types for the ALU.
`default_nettype none
package cabnf_pkg;

	typedef enum logic [4:0] {
		OP_ADD8  = 5'd0,  OP_ADC8  = 5'd1,  OP_SUB8  = 5'd2,  OP_SBC8  = 5'd3,
		OP_AND8  = 5'd4,  OP_OR8   = 5'd5,  OP_XOR8  = 5'd6,  OP_INC8  = 5'd7,
		OP_DEC8  = 5'd8,  OP_INC16 = 5'd9,  OP_DEC16 = 5'd10, OP_ADD16 = 5'd11,
		OP_ADC16 = 5'd12, OP_SUB16 = 5'd13, OP_SBC16 = 5'd14, OP_SWAP  = 5'd15,
		OP_MUL   = 5'd16, OP_DIV   = 5'd17, OP_SAL   = 5'd18, OP_SHL   = 5'd19,
		OP_SAR   = 5'd20, OP_SHR   = 5'd21, OP_RLC   = 5'd22, OP_ROL   = 5'd23,
		OP_RRC   = 5'd24, OP_ROR   = 5'd25, OP_NOT   = 5'd26, OP_NEG   = 5'd27,
		OP_SEX   = 5'd28, OP_RSV29 = 5'd29, OP_RSV30 = 5'd30, OP_RSV31 = 5'd31
	} op_t;

	typedef struct packed {
		logic s;
		logic v;
		logic c;
		logic z;
	} flags_t;

	// Request from the sequencer to the shared multiply/divide unit.
	typedef struct packed {
		logic        start;
		logic        is_div;
		logic [15:0] a;
		logic [7:0]  b;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] prod;
		logic [7:0]  quot;
		logic [7:0]  rem;
	} md_rsp_t;

	localparam int unsigned MD_STEPS = 8;

endpackage
`default_nettype wire

>>> rtl/cabnf_muldiv.sv
// Shared bit-serial unit: shift-add multiply and restoring divide, one bit a cycle.
`default_nettype none
module cabnf_muldiv (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cabnf_pkg::md_req_t req,
	output cabnf_pkg::md_rsp_t      rsp
);
	logic        busy_q;
	logic        done_q;
	logic        is_div_q;
	logic [3:0]  cnt_q;
	logic [15:0] acc_q;
	logic [15:0] x_q;
	logic [7:0]  b_q;
	logic [8:0]  trial;
	logic [8:0]  prem;

	// For divide, acc_q holds the partial remainder (low 8 bits used) and x_q the dividend bits.
	assign prem  = {acc_q[7:0], x_q[15]};
	assign trial = prem - {1'b0, b_q};

	// done_q rises the cycle after the last step, once acc_q and x_q hold the final values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == 4'(cabnf_pkg::MD_STEPS - 1)) busy_q <= 1'b0;
			done_q <= (cnt_q == 4'(cabnf_pkg::MD_STEPS - 1));
			cnt_q  <= cnt_q + 4'd1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			is_div_q <= req.is_div;
			b_q      <= req.b;
			if (req.is_div) begin
				acc_q <= {8'd0, req.a[15:8]};
				x_q   <= {req.a[7:0], 8'd0};
			end else begin
				acc_q <= '0;
				x_q   <= {8'd0, req.a[7:0]};
			end
		end else if (busy_q) begin
			if (is_div_q) begin
				// The high byte is below the divisor here, so the remainder fits 8 bits.
				if (!trial[8]) acc_q <= {7'd0, trial};
				else           acc_q <= {7'd0, prem};
				x_q <= {x_q[14:0], ~trial[8]};
			end else begin
				acc_q <= acc_q + (x_q[7 - cnt_q[2:0]] ? ({8'd0, b_q} << (3'd7 - cnt_q[2:0]))
					: 16'd0);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;
	assign rsp.quot = x_q[7:0];
	assign rsp.rem  = acc_q[7:0];
endmodule
`default_nettype wire

>>> rtl/cabnf_logic.sv
// Combinational datapath for all operations except multiply and divide.
`default_nettype none
module cabnf_logic (
	input  wire logic [4:0]       func,
	input  wire logic [15:0]      a16,
	input  wire logic [15:0]      b16,
	input  wire logic             dm,
	input  wire logic             nm,
	input  wire cabnf_pkg::flags_t fin,
	output logic [15:0]           r,
	output cabnf_pkg::flags_t     fout
);
	logic [7:0]  a, b, r8;
	logic        cin, ci;
	logic [9:0]  s9;
	logic [5:0]  sn;
	logic [4:0]  lowsum;
	logic [7:0]  tn, lowd;
	logic [9:0]  d10;
	logic [8:0]  bc;
	logic        borrow;
	logic [16:0] s17;
	logic [16:0] bc17;

	always_comb begin
		a = a16[7:0];
		b = b16[7:0];
		cin = fin.c;
		ci = (func == cabnf_pkg::OP_ADC8 || func == cabnf_pkg::OP_SBC8 ||
			func == cabnf_pkg::OP_ADC16 || func == cabnf_pkg::OP_SBC16) ? cin : 1'b0;
		r = a16;
		fout = fin;
		r8 = '0;
		s9 = '0; sn = '0; lowsum = '0; tn = '0; lowd = '0; d10 = '0; bc = '0;
		borrow = 1'b0; s17 = '0; bc17 = '0;
		unique case (cabnf_pkg::op_t'(func))
			cabnf_pkg::OP_ADD8, cabnf_pkg::OP_ADC8: begin
				fout = '0;
				if (nm) begin
					sn = {2'b0, a[3:0]} + {2'b0, b[3:0]} + {5'd0, ci};
					if (dm && sn >= 6'd10) sn = sn + 6'd6;
					fout.z = (sn[3:0] == 4'd0);
					fout.c = (sn >= 6'd16);
					if (!dm) begin
						fout.v = (a[3] ^ sn[3]) && !(a[3] ^ b[3]);
						fout.s = sn[3];
					end
					r = {12'd0, sn[3:0]};
				end else begin
					s9 = {2'b0, a} + {2'b0, b} + {9'd0, ci};
					if (dm) begin
						lowsum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
						if (lowsum >= 5'd10) s9 = s9 + 10'd6;
						if (s9 >= 10'h0A0) s9 = s9 + 10'h060;
					end else begin
						fout.v = (a[7] ^ s9[7]) && !(a[7] ^ b[7]);
						fout.s = s9[7];
					end
					fout.z = (s9[7:0] == 8'd0);
					fout.c = (s9 >= 10'h100);
					r = {8'd0, s9[7:0]};
				end
			end
			cabnf_pkg::OP_SUB8, cabnf_pkg::OP_SBC8: begin
				fout = '0;
				bc = {1'b0, b} + {8'd0, ci};
				if (nm) begin
					tn = {4'd0, a[3:0]} - {4'd0, b[3:0]} - {7'd0, ci};
					if (dm && tn >= 8'd10) tn = tn - 8'd6;
					fout.z = (tn[3:0] == 4'd0);
					fout.c = (tn >= 8'd16);
					if (!dm) begin
						fout.v = (a[3] ^ tn[3]) && (a[3] ^ b[3]);
						fout.s = tn[3];
					end
					r = {12'd0, tn[3:0]};
				end else if (dm) begin
					lowd = {4'd0, a[3:0]} - {4'd0, b[3:0]} - {7'd0, ci};
					d10 = {2'd0, a} + 10'h200 - {1'b0, bc};
					borrow = ({1'b0, a} < bc);
					if (lowd >= 8'd10) d10 = d10 - 10'd6;
					r8 = d10[7:0];
					if (borrow || r8 >= 8'hA0) r8 = r8 - 8'h60;
					fout.z = (r8 == 8'd0);
					fout.c = borrow;
					r = {8'd0, r8};
				end else begin
					r8 = a - b - {7'd0, ci};
					fout.z = (r8 == 8'd0);
					fout.c = ({1'b0, a} < bc);
					fout.v = (a[7] ^ r8[7]) && (a[7] ^ b[7]);
					fout.s = r8[7];
					r = {8'd0, r8};
				end
			end
			cabnf_pkg::OP_AND8, cabnf_pkg::OP_OR8, cabnf_pkg::OP_XOR8,
			cabnf_pkg::OP_NOT: begin
				if (func == cabnf_pkg::OP_AND8)     r8 = a & b;
				else if (func == cabnf_pkg::OP_OR8) r8 = a | b;
				else if (func == cabnf_pkg::OP_XOR8) r8 = a ^ b;
				else                                r8 = ~a;
				fout.z = (r8 == 8'd0);
				fout.s = r8[7];
				r = {8'd0, r8};
			end
			cabnf_pkg::OP_INC8, cabnf_pkg::OP_DEC8: begin
				r8 = (func == cabnf_pkg::OP_INC8) ? a + 8'd1 : a - 8'd1;
				fout.z = (r8 == 8'd0);
				r = {8'd0, r8};
			end
			cabnf_pkg::OP_INC16, cabnf_pkg::OP_DEC16: begin
				r = (func == cabnf_pkg::OP_INC16) ? a16 + 16'd1 : a16 - 16'd1;
				fout.z = (r == 16'd0);
			end
			cabnf_pkg::OP_ADD16, cabnf_pkg::OP_ADC16: begin
				s17 = {1'b0, a16} + {1'b0, b16} + {16'd0, ci};
				r = s17[15:0];
				fout.z = (r == 16'd0);
				fout.c = s17[16];
				fout.v = (a16[15] ^ r[15]) && !(a16[15] ^ b16[15]);
				fout.s = r[15];
			end
			cabnf_pkg::OP_SUB16, cabnf_pkg::OP_SBC16: begin
				bc17 = {1'b0, b16} + {16'd0, ci};
				r = a16 - b16 - {15'd0, ci};
				fout.z = (r == 16'd0);
				fout.c = ({1'b0, a16} < bc17);
				fout.v = (a16[15] ^ r[15]) && (a16[15] ^ b16[15]);
				fout.s = r[15];
			end
			cabnf_pkg::OP_SWAP: r = {8'd0, a[3:0], a[7:4]};
			cabnf_pkg::OP_SAL, cabnf_pkg::OP_SHL, cabnf_pkg::OP_SAR,
			cabnf_pkg::OP_SHR, cabnf_pkg::OP_RLC, cabnf_pkg::OP_ROL,
			cabnf_pkg::OP_RRC, cabnf_pkg::OP_ROR: begin
				unique case (cabnf_pkg::op_t'(func))
					cabnf_pkg::OP_SAL, cabnf_pkg::OP_SHL: r8 = {a[6:0], 1'b0};
					cabnf_pkg::OP_SAR: r8 = {a[7], a[7:1]};
					cabnf_pkg::OP_SHR: r8 = {1'b0, a[7:1]};
					cabnf_pkg::OP_RLC: r8 = {a[6:0], cin};
					cabnf_pkg::OP_ROL: r8 = {a[6:0], a[7]};
					cabnf_pkg::OP_RRC: r8 = {cin, a[7:1]};
					default:           r8 = {a[0], a[7:1]};
				endcase
				fout.c = (func == cabnf_pkg::OP_SAL || func == cabnf_pkg::OP_SHL ||
					func == cabnf_pkg::OP_RLC || func == cabnf_pkg::OP_ROL) ? a[7] : a[0];
				if (func == cabnf_pkg::OP_SAL) fout.v = a[6] ^ a[7];
				if (func == cabnf_pkg::OP_SAR) fout.v = 1'b0;
				fout.z = (r8 == 8'd0);
				fout.s = r8[7];
				r = {8'd0, r8};
			end
			cabnf_pkg::OP_NEG: begin
				r8 = 8'd0 - a;
				fout.z = (r8 == 8'd0);
				fout.c = (r8 != 8'd0);
				fout.v = (r8 == 8'h80);
				fout.s = r8[7];
				r = {8'd0, r8};
			end
			cabnf_pkg::OP_SEX: r = {{8{a[7]}}, a};
			default: r = a16;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/cpu_alu_with_bcd_nibble_flags.sv
// Top level: handshake, sequencer, flag register and result register of the ALU.
//
// Usage: an operation (func, operand_a, operand_b, decimal_mode, nibble_mode) is
// transferred on the input channel (valid/ready). One result with the new zero,
// carry, overflow and sign flags comes back on the output channel (out_valid/
// out_ready). Flags persist between operations and feed add/sub-with-carry and
// the rotates through carry.
// Sequencing: most operations go from the input transfer through the execute
// state straight to the output. Multiply and divide use the shared bit-serial
// unit: the execute state starts it, the sequencer waits in the wait state while
// it iterates, then collects the result and raises out_valid. A divide by zero
// or with quotient overflow skips the unit and goes from the execute state to
// the output like the rest.
// One operation is in flight at a time; the input is ready again the cycle
// after the result has been transferred out.
// Reset clears the flags to zero and empties the block. If the receiver stalls,
// the result and flags hold on the output until transferred.
`default_nettype none
module cpu_alu_with_bcd_nibble_flags (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [4:0]  func,
	input  wire logic [15:0] operand_a,
	input  wire logic [15:0] operand_b,
	input  wire logic        decimal_mode,
	input  wire logic        nibble_mode,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      result,
	output logic             zero_flag,
	output logic             carry_flag,
	output logic             overflow_flag,
	output logic             sign_flag
);
	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT, ST_OUT} state_t;

	state_t             state_q;
	cabnf_pkg::flags_t  flags_q;
	logic [4:0]         func_q;
	logic [15:0]        a_q, b_q;
	logic               dm_q, nm_q;
	logic [15:0]        result_q;
	logic [15:0]        lr;
	cabnf_pkg::flags_t  lf;
	cabnf_pkg::md_req_t req;
	cabnf_pkg::md_rsp_t rsp;
	logic               is_md, is_div, div_bad;

	cabnf_logic u_logic (
		.func(func_q), .a16(a_q), .b16(b_q), .dm(dm_q), .nm(nm_q),
		.fin(flags_q), .r(lr), .fout(lf)
	);

	assign is_div = (func_q == cabnf_pkg::OP_DIV);
	assign is_md  = is_div || (func_q == cabnf_pkg::OP_MUL);
	// Quotient overflows exactly when the high byte of the dividend reaches the divisor.
	assign div_bad = (b_q[7:0] == 8'd0) || (a_q[15:8] >= b_q[7:0]);

	assign req.start  = (state_q == ST_EXEC) && is_md && !(is_div && div_bad);
	assign req.is_div = is_div;
	assign req.a      = a_q;
	assign req.b      = b_q[7:0];

	cabnf_muldiv u_md (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign result        = result_q;
	assign zero_flag     = flags_q.z;
	assign carry_flag    = flags_q.c;
	assign overflow_flag = flags_q.v;
	assign sign_flag     = flags_q.s;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q <= func;
			a_q    <= operand_a;
			b_q    <= operand_b;
			dm_q   <= decimal_mode;
			nm_q   <= nibble_mode;
		end
	end

	// Flag vectors below are packed as {sign, overflow, carry, zero}.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			flags_q  <= '0;
			result_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (is_div && div_bad) begin
						result_q <= a_q;
						flags_q  <= (b_q[7:0] != 8'd0) ? 4'b1100 : 4'b0000;
						state_q  <= ST_OUT;
					end else if (is_md) begin
						state_q <= ST_WAIT;
					end else begin
						result_q <= lr;
						flags_q  <= lf;
						state_q  <= ST_OUT;
					end
				end
				ST_WAIT: if (rsp.done) begin
					if (is_div) begin
						result_q <= {rsp.rem, rsp.quot};
						flags_q  <= {rsp.quot[7], 2'b00, (rsp.quot == 8'd0)};
					end else begin
						result_q <= rsp.prod;
						flags_q  <= {rsp.prod[15], 2'b00, (rsp.prod == 16'd0)};
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_md_only_when_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (state_q == ST_EXEC))
		else $error("muldiv started outside execute");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |=> (state_q == ST_WAIT || state_q == ST_OUT))
		else $error("left wait without result");
	a_out_after_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result_q) && $stable(flags_q)))
		else $error("result changed while stalled");
endmodule
`default_nettype wire
